// ===== design/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
package deq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_GET        = 3'd4,
		OP_SIZE       = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	// Result control that rides along with the RAM read.
	typedef struct packed {
		logic    take_word;
		status_t status;
	} res_ctrl_t;

endpackage

// ===== design/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/deq_ctrl.sv =====
// Head pointer and count registers, operation decode and RAM addressing.
module deq_ctrl #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [2:0]                 operation,
	input  logic [$clog2(DEPTH+1)-1:0] position,
	output logic                       we,
	output logic [$clog2(DEPTH)-1:0]   waddr,
	output logic                       re,
	output logic [$clog2(DEPTH)-1:0]   raddr,
	output deq_pkg::res_ctrl_t         res,
	output logic [$clog2(DEPTH+1)-1:0] count_next
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] pos_m1;
	logic          full, empty, bad_pos;
	op_t           op;

	// front + offset modulo DEPTH; both operands are below DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign op      = op_t'(operation);
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign bad_pos = (position == '0) || (position > count_q);
	assign pos_m1  = position - CW'(1);

	always_comb begin
		front_d       = front_q;
		count_d       = count_q;
		we            = 1'b0;
		waddr         = wrap_add(front_q, count_q[AW-1:0]);
		re            = 1'b0;
		raddr         = front_q;
		res.take_word = 1'b0;
		res.status    = ST_OK;
		case (op)
			OP_PUSH_BACK: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					we      = accept;
					count_d = count_q + CW'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					front_d = wrap_add(front_q, AW'(DEPTH - 1));
					waddr   = front_d;
					we      = accept;
					count_d = count_q + CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					count_d       = count_q - CW'(1);
					raddr         = wrap_add(front_q, count_d[AW-1:0]);
					re            = accept;
					res.take_word = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					front_d       = wrap_add(front_q, AW'(1));
					count_d       = count_q - CW'(1);
					re            = accept;
					res.take_word = 1'b1;
				end
			end
			OP_GET: begin
				if (bad_pos) begin
					res.status = ST_BAD_INDEX;
				end else begin
					raddr         = wrap_add(front_q, pos_m1[AW-1:0]);
					re            = accept;
					res.take_word = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign count_next = count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && empty && (op == OP_POP_BACK || op == OP_POP_FRONT))
		|-> (!re && !we && res.status == ST_EMPTY))
		else $error("pop on empty queue touched storage");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && we) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the count");

	a_read_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && re && (op == OP_POP_BACK || op == OP_POP_FRONT))
		|=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not shrink the count");

	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re))
		else $error("read and write in one beat");
`endif

endmodule

// ===== design/double_ended_queue.sv =====
// A result beat is presented on done in the cycle after start is taken.
// Throughput: one operation per cycle; busy stays low, the RAM read and the
// pointer/count update both fit in the accepting cycle.
// Results cannot be stalled; each beat is shown for exactly one cycle.
// Reset clears head pointer and count; stored words are undefined until pushed.
module double_ended_queue #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 operation,
	input  logic [DATA_WIDTH-1:0]      push_word,
	input  logic [$clog2(DEPTH+1)-1:0] position,
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      result_word,
	output logic [$clog2(DEPTH+1)-1:0] occupancy,
	output logic [1:0]                 status
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                  accept;
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	res_ctrl_t             res_c;
	logic [CW-1:0]         count_next;

	logic                  valid_s1;
	res_ctrl_t             res_s1;
	logic [CW-1:0]         occ_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.position  (position),
		.we        (ram_we),
		.waddr     (ram_waddr),
		.re        (ram_re),
		.raddr     (ram_raddr),
		.res       (res_c),
		.count_next(count_next)
	);

	deq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(push_word),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_c;
			occ_s1 <= count_next;
		end
	end

	assign done        = valid_s1;
	assign result_word = res_s1.take_word ? ram_rdata : '0;
	assign occupancy   = occ_s1;
	assign status      = res_s1.status;

endmodule

// ===== test/deque_check_pkg.sv =====
// Scoreboard for the double-ended queue, with its own model of the ring buffer.
package deque_check_pkg;
	import deq_pkg::*;

	localparam int SLOTS       = 64;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [31:0] word;
		logic [6:0]  count;
		status_t     st;
	} deque_beat_t;

	class deque_scoreboard;
		logic [31:0] words [SLOTS];
		bit [5:0]    head;
		int unsigned level;
		deque_beat_t expected_beats[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned peak;
		int unsigned status_seen [4];

		// Ring slot at an offset from the front, wraps at SLOTS.
		function bit [5:0] slot(int unsigned offset);
			return 6'(head + offset);
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		function void complain(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] MISMATCH %s", $time, msg);
		endfunction

		// Apply one accepted command to the model and queue the beat it must produce.
		function void note_command(logic [2:0] op, logic [31:0] word, logic [6:0] pos);
			deque_beat_t e;
			e.word = '0;
			e.st   = ST_OK;
			case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (level >= SLOTS)
					e.st = ST_FULL;
				else if (op == OP_PUSH_BACK) begin
					words[slot(level)] = word;
					level++;
				end else begin
					head = slot(SLOTS - 1);
					words[head] = word;
					level++;
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (level == 0)
					e.st = ST_EMPTY;
				else if (op == OP_POP_BACK) begin
					level--;
					e.word = words[slot(level)];
				end else begin
					e.word = words[head];
					head = slot(1);
					level--;
				end
			end
			OP_GET: begin
				if (pos == 0 || pos > level)
					e.st = ST_BAD_INDEX;
				else
					e.word = words[slot(pos - 1)];
			end
			default: ;
			endcase
			e.count = 7'(level);
			if (level > peak)
				peak = level;
			expected_beats.push_back(e);
		endfunction

		function void check_beat(logic [31:0] word, logic [6:0] count, logic [1:0] st);
			deque_beat_t e;
			checked++;
			if (expected_beats.size() == 0) begin
				complain($sformatf("beat with nothing expected: word %h count %0d status %0d",
					word, count, st));
				return;
			end
			e = expected_beats.pop_front();
			status_seen[e.st]++;
			if (word !== e.word || count !== e.count || st !== e.st)
				complain($sformatf({"expected word %h count %0d status %0d, ",
					"got word %h count %0d status %0d"},
					e.word, e.count, e.st, word, count, st));
		endfunction
	endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench for the double-ended queue: directed and random command streams.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;
	import deque_check_pkg::*;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int RANDOM_ITEMS = 1550;
	localparam int QUIET_START  = 700;
	localparam int QUIET_END    = 1000;
	localparam int STALL_LIMIT  = 1000;

	typedef enum {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  operation;
	logic [31:0] push_word;
	logic [6:0]  position;
	logic        done;
	logic [31:0] result_word;
	logic [6:0]  occupancy;
	logic [1:0]  status;

	deque_scoreboard shadow = new();
	int unsigned depth_guess = 0;
	int unsigned accepted = 0;
	int unsigned stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	double_ended_queue #(
		.DEPTH(64),
		.DATA_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.push_word(push_word),
		.position(position),
		.done(done),
		.result_word(result_word),
		.occupancy(occupancy),
		.status(status)
	);

	// Beats are taken here on the pre-edge values; the note goes first so a
	// command and its result never race.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				shadow.note_command(operation, push_word, position);
				accepted++;
			end
			if (done)
				shadow.check_beat(result_word, occupancy, status);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic send_command(logic [2:0] op, logic [31:0] word, logic [6:0] pos);
		start     <= 1'b1;
		operation <= op;
		push_word <= word;
		position  <= pos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		case (op)
		OP_PUSH_BACK, OP_PUSH_FRONT: if (depth_guess < SLOTS) depth_guess++;
		OP_POP_BACK, OP_POP_FRONT:   if (depth_guess > 0) depth_guess--;
		default: ;
		endcase
	endtask

	// Start low, payload scrambled so nothing leaks through while idle.
	task automatic idle_cycles(int n);
		repeat (n) begin
			start     <= 1'b0;
			operation <= 3'($urandom);
			push_word <= $urandom;
			position  <= 7'($urandom);
			@(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		phase_t      mode;
		int          phase_left;
		int          push_cut;
		int          pop_cut;
		int          r;
		int          n;
		logic [2:0]  op;
		logic [6:0]  pos;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= OP_SIZE;
		push_word <= '0;
		position  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue errors, spare codes, word extremes, index edges.
		send_command(OP_SIZE, $urandom, 7'($urandom));
		send_command(OP_POP_BACK, $urandom, 7'($urandom));
		send_command(OP_POP_FRONT, $urandom, 7'($urandom));
		send_command(OP_GET, $urandom, 7'd0);
		send_command(OP_GET, $urandom, 7'd1);
		send_command(OP_SPARE_A, $urandom, 7'($urandom));
		send_command(OP_SPARE_B, $urandom, 7'($urandom));
		send_command(OP_PUSH_BACK, 32'h0000_0000, 7'($urandom));
		send_command(OP_PUSH_BACK, 32'hFFFF_FFFF, 7'($urandom));
		send_command(OP_PUSH_FRONT, 32'hA5A5_A5A5, 7'($urandom));
		send_command(OP_PUSH_FRONT, 32'h5A5A_5A5A, 7'($urandom));
		send_command(OP_GET, $urandom, 7'd1);
		send_command(OP_GET, $urandom, 7'd4);
		send_command(OP_GET, $urandom, 7'd5);
		send_command(OP_GET, $urandom, 7'd0);
		send_command(OP_GET, $urandom, 7'd127);
		send_command(OP_SIZE, $urandom, 7'($urandom));
		send_command(OP_POP_FRONT, $urandom, 7'($urandom));
		send_command(OP_POP_BACK, $urandom, 7'($urandom));
		send_command(OP_POP_BACK, $urandom, 7'($urandom));
		send_command(OP_POP_FRONT, $urandom, 7'($urandom));
		send_command(OP_POP_FRONT, $urandom, 7'($urandom));
		send_command(OP_SIZE, $urandom, 7'($urandom));
		wait_for_results();

		// Random: alternating fill, drain and mixed phases; the first three run 160
		// commands each, pushing toward full and then draining toward empty.
		mode = FILL_PHASE;
		phase_left = 160;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				mode = phase_t'((int'(mode) + 1) % 3);
				phase_left = (i < 400) ? 160 : $urandom_range(60, 200);
			end
			phase_left--;
			if (i == RANDOM_ITEMS / 2)
				wait_for_results();
			if ((i < QUIET_START || i >= QUIET_END) && $urandom_range(0, 99) < 7)
				idle_cycles($urandom_range(1, 3));

			case (mode)
			FILL_PHASE: begin
				push_cut = 70;
				pop_cut  = 80;
			end
			DRAIN_PHASE: begin
				push_cut = 20;
				pop_cut  = 75;
			end
			default: begin
				push_cut = 35;
				pop_cut  = 65;
			end
			endcase

			r = $urandom_range(0, 99);
			if (r < push_cut)
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else if (r < pop_cut)
				op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
			else if (r < 90)
				op = OP_GET;
			else if (r < 96)
				op = OP_SIZE;
			else
				op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;

			// Mostly live positions, some just outside, some anywhere in the field.
			n = $urandom_range(0, 9);
			if (n < 7 && depth_guess > 0)
				pos = 7'($urandom_range(1, depth_guess));
			else if (n < 8)
				pos = $urandom_range(0, 1) ? 7'd0 : 7'(depth_guess + 1);
			else
				pos = 7'($urandom);

			send_command(op, $urandom, pos);
		end

		wait_for_results();
		repeat (4) @(posedge clk);

		$display("Run covered %0d commands and %0d result beats, peak occupancy %0d of %0d.",
			accepted, shadow.checked, shadow.peak, SLOTS);
		$display("Statuses seen: ok %0d, empty %0d, full %0d, bad index %0d; errors %0d.",
			shadow.status_seen[ST_OK], shadow.status_seen[ST_EMPTY],
			shadow.status_seen[ST_FULL], shadow.status_seen[ST_BAD_INDEX], shadow.errors);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
